// ===== design/lbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the label boundary marker.
// Used by every module of the block but the command queue; depends on nothing.

package lbm_pkg;

  // Fixed field widths of the pixel stream and the configuration port, and size limits.
  localparam int IN_LABEL_W   = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [WIDTH_REG_W-1:0]  RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Item codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [7:0] WHITE = 8'd255;

  typedef struct packed {
    logic                  op;
    logic [IN_LABEL_W-1:0] seg_label;
    logic [7:0]            in_red;
    logic [7:0]            in_green;
    logic [7:0]            in_blue;
  } lbm_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       on_boundary;
    logic       end_of_frame;
  } lbm_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lbm_rgb_t;

  // Per-advance control handed from the front end to the back end.
  typedef struct packed {
    logic emit;
    logic clamp_left;
    logic clamp_right;
    logic clamp_top;
    logic clamp_bottom;
    logic last;
  } lbm_ctrl_t;

endpackage

// ===== design/lbm_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, item classification and frame counters.
// Turns accepted words into window advance commands; uses lbm_pkg.

module lbm_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int LAB_W     = 16,
  parameter int AW        = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  lbm_pkg::lbm_in_t                 in_i,
  output logic                             in_stall_o,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output lbm_pkg::lbm_ctrl_t               cmd_ctrl_o,
  output logic [LAB_W-1:0]                 cmd_label_o,
  output lbm_pkg::lbm_rgb_t                cmd_rgb_o,
  output logic [AW-1:0]                    cmd_addr_o
);
  import lbm_pkg::*;

  logic [WIDTH_REG_W-1:0]  fw_q, fw_d;
  logic [HEIGHT_REG_W-1:0] fh_q, fh_d;
  logic [AW-1:0]           adv_x_q, adv_x_d;
  logic [ROW_W-1:0]        in_y_q, in_y_d;
  logic                    in_done_q, in_done_d;
  logic [AW-1:0]           out_x_q, out_x_d;
  logic [ROW_W-1:0]        out_y_q, out_y_d;
  logic                    pad_q, pad_d;

  logic [AW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic             in_acc, pix_acc, fl_acc, restart, pix_emit, fl_emit, cfg_hit;
  logic [AW-1:0]    cur_x, ox, adv_x_next;
  logic [ROW_W-1:0] cur_y, oy;
  logic             out_last;

  // Effective frame size: zero reads as one, large values saturate.
  always_comb begin
    if (fw_q == '0) begin
      w_last = '0;
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(fw_q - 11'd1);
    end
    if (fh_q == '0) begin
      h_last = '0;
    end else if (fh_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(fh_q - 13'd1);
    end
  end

  assign in_stall_o = q_full_i || pad_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_i.op == OP_PIXEL);
  assign fl_acc     = in_acc && (in_i.op == OP_FLUSH);
  // A pixel after a fully received frame drops what is pending and starts over.
  assign restart    = pix_acc && in_done_q;

  assign cur_x      = restart ? '0 : adv_x_q;
  assign cur_y      = restart ? '0 : in_y_q;
  assign ox         = restart ? '0 : out_x_q;
  assign oy         = restart ? '0 : out_y_q;
  assign adv_x_next = (cur_x == w_last) ? '0 : cur_x + 1'b1;
  assign out_last   = (ox == w_last) && (oy == h_last);

  // A pixel releases a result once a full row plus one pixel lies behind it.
  assign pix_emit = (cur_y != '0) && ((cur_y != ROW_W'(1)) || (cur_x != '0));
  assign fl_emit  = fl_acc && in_done_q;

  assign q_push_o = pix_acc || fl_emit || (pad_q && !q_full_i);

  always_comb begin
    cmd_ctrl_o.emit         = (pix_acc && pix_emit) || fl_emit;
    cmd_ctrl_o.clamp_left   = (ox == '0);
    cmd_ctrl_o.clamp_right  = (ox == w_last);
    cmd_ctrl_o.clamp_top    = (oy == '0);
    cmd_ctrl_o.clamp_bottom = (oy == h_last);
    cmd_ctrl_o.last         = out_last;
  end

  assign cmd_label_o     = in_i.seg_label[LAB_W-1:0];
  assign cmd_rgb_o.red   = in_i.in_red;
  assign cmd_rgb_o.green = in_i.in_green;
  assign cmd_rgb_o.blue  = in_i.in_blue;
  assign cmd_addr_o      = cur_x;

  always_comb begin
    fw_d      = fw_q;
    fh_d      = fh_q;
    adv_x_d   = adv_x_q;
    in_y_d    = in_y_q;
    in_done_d = in_done_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    pad_d     = pad_q;
    cfg_hit   = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          fw_d    = cfg_data_i[WIDTH_REG_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          fh_d    = cfg_data_i[HEIGHT_REG_W-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      adv_x_d   = '0;
      in_y_d    = '0;
      in_done_d = 1'b0;
      out_x_d   = '0;
      out_y_d   = '0;
      pad_d     = 1'b0;
    end else if (pix_acc) begin
      adv_x_d   = adv_x_next;
      in_y_d    = cur_y;
      in_done_d = 1'b0;
      if (cur_x == w_last) begin
        if (cur_y == h_last) begin
          in_done_d = 1'b1;
          in_y_d    = '0;
          // In a one-row frame the first flush is two positions past the
          // last pixel, so one silent advance fills the gap.
          pad_d     = (h_last == '0);
        end else begin
          in_y_d = cur_y + 1'b1;
        end
      end
      out_x_d = ox;
      out_y_d = oy;
      if (pix_emit) begin
        if (ox == w_last) begin
          out_x_d = '0;
          out_y_d = oy + 1'b1;
        end else begin
          out_x_d = ox + 1'b1;
        end
      end
    end else if (fl_emit) begin
      if (out_last) begin
        adv_x_d   = '0;
        in_y_d    = '0;
        in_done_d = 1'b0;
        out_x_d   = '0;
        out_y_d   = '0;
      end else begin
        adv_x_d = adv_x_next;
        if (ox == w_last) begin
          out_x_d = '0;
          out_y_d = oy + 1'b1;
        end else begin
          out_x_d = ox + 1'b1;
        end
      end
    end else if (pad_q && !q_full_i) begin
      adv_x_d = adv_x_next;
      pad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= RESET_FRAME_WIDTH;
      fh_q      <= RESET_FRAME_HEIGHT;
      adv_x_q   <= '0;
      in_y_q    <= '0;
      in_done_q <= 1'b0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      pad_q     <= 1'b0;
    end else begin
      fw_q      <= fw_d;
      fh_q      <= fh_d;
      adv_x_q   <= adv_x_d;
      in_y_q    <= in_y_d;
      in_done_q <= in_done_d;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      pad_q     <= pad_d;
    end
  end

endmodule

// ===== design/lbm_cmd_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Generic register FIFO; depends on nothing.

module lbm_cmd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/lbm_back.sv =====
`timescale 1ns / 1ps
// Back end: line memories, 3x3 label window, colour delay and output register.
// Consumes advance commands from the queue; uses lbm_pkg.

module lbm_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int LAB_W     = 16,
  parameter int AW        = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  lbm_pkg::lbm_ctrl_t cmd_ctrl_i,
  input  logic [LAB_W-1:0]   cmd_label_i,
  input  lbm_pkg::lbm_rgb_t  cmd_rgb_i,
  input  logic [AW-1:0]      cmd_addr_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbm_pkg::lbm_out_t  out_o
);
  import lbm_pkg::*;

  localparam int RGB_W = $bits(lbm_rgb_t);

  // One row up: label and colour. Two rows up: label only.
  logic [LAB_W+RGB_W-1:0] row1_mem [MAX_WIDTH];
  logic [LAB_W-1:0]       row2_mem [MAX_WIDTH];

  logic                   adv_en, b_wr;
  logic                   a_valid_q, b_valid_q, out_valid_q;
  lbm_ctrl_t              a_ctrl_q, b_ctrl_q;
  logic [LAB_W-1:0]       a_label_q;
  logic [AW-1:0]          a_addr_q;
  logic [LAB_W+RGB_W-1:0] row1_rd_q;
  logic [LAB_W-1:0]       row2_rd_q;
  logic [LAB_W-1:0]       row1_rd_label;
  lbm_rgb_t               row1_rd_rgb;
  logic [LAB_W-1:0]       win_q [3][3];
  logic [LAB_W-1:0]       new_col [3];
  lbm_rgb_t               prev_rgb_q, b_rgb_q;
  lbm_out_t               out_q;
  logic                   boundary;
  logic [1:0]             rr, cc;

  // The whole back end moves together whenever the output register can take.
  assign adv_en  = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv_en && q_valid_i;
  assign b_wr    = adv_en && a_valid_q;

  assign row1_rd_label = row1_rd_q[LAB_W+RGB_W-1:RGB_W];
  assign row1_rd_rgb   = lbm_rgb_t'(row1_rd_q[RGB_W-1:0]);

  assign new_col[0] = row2_rd_q;
  assign new_col[1] = row1_rd_label;
  assign new_col[2] = a_label_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      row1_mem[cmd_addr_i] <= {cmd_label_i, cmd_rgb_i};
      row1_rd_q            <= row1_mem[cmd_addr_i];
      // The previous advance may be writing this very column (one-pixel rows).
      if (b_wr && (a_addr_q == cmd_addr_i)) begin
        row2_rd_q <= row1_rd_label;
      end else begin
        row2_rd_q <= row2_mem[cmd_addr_i];
      end
      a_ctrl_q  <= cmd_ctrl_i;
      a_label_q <= cmd_label_i;
      a_addr_q  <= cmd_addr_i;
    end
    if (b_wr) begin
      row2_mem[a_addr_q] <= row1_rd_label;
    end
  end

  // Window columns run oldest to newest; the centre sits in the middle.
  // The colour read one row up belongs to the next centre, so it waits a step.
  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= new_col[r];
      end
      prev_rgb_q <= row1_rd_rgb;
      b_rgb_q    <= prev_rgb_q;
      b_ctrl_q   <= a_ctrl_q;
    end
  end

  // Rows and columns outside the frame fold back onto the centre.
  always_comb begin
    boundary = 1'b0;
    rr       = 2'd1;
    cc       = 2'd1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && b_ctrl_q.clamp_top) || (r == 2 && b_ctrl_q.clamp_bottom)) begin
          rr = 2'd1;
        end else begin
          rr = 2'(r);
        end
        if ((c == 0 && b_ctrl_q.clamp_left) || (c == 2 && b_ctrl_q.clamp_right)) begin
          cc = 2'd1;
        end else begin
          cc = 2'(c);
        end
        if (win_q[rr][cc] != win_q[1][1]) begin
          boundary = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_en) begin
      out_q.out_red      <= boundary ? WHITE : b_rgb_q.red;
      out_q.out_green    <= boundary ? WHITE : b_rgb_q.green;
      out_q.out_blue     <= boundary ? WHITE : b_rgb_q.blue;
      out_q.on_boundary  <= boundary;
      out_q.end_of_frame <= b_ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_en) begin
      a_valid_q   <= q_valid_i;
      b_valid_q   <= a_valid_q && a_ctrl_q.emit;
      out_valid_q <= b_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== design/label_boundary_marker.sv =====
`timescale 1ns / 1ps
// Top level of the label boundary marker: front end, command queue, back end.
// Uses lbm_pkg, lbm_front, lbm_cmd_queue and lbm_back.

// Marks segment boundaries on a raster pixel stream. Each pixel carries a
// label and a colour; a pixel whose clamped 3x3 label window holds a label
// other than its own leaves white, any other pixel keeps its colour. The
// block takes one word per cycle on the input while it is not stalled, and
// gives at most one per cycle on the output. A released result passes
// through the command queue, the a and b stages and the output register
// (pixel k is released by pixel k+width+1, the tail of the frame by flush
// words). The rate is set by the line memories of MAX_WIDTH entries, which
// take one read and one write per advance. After the last pixel of a
// one-row frame the input stalls while the window steps once without a
// result. A four-entry command queue lets the input keep flowing while the
// output is stalled, until the queue fills. The line memories need no
// clearing after reset: entries not yet written in the current frame only
// ever land in window places that edge clamping discards. Write the frame
// size only while the block is idle; a write restarts the frame.

module label_boundary_marker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lbm_pkg::lbm_in_t               in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lbm_pkg::lbm_out_t              out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lbm_pkg::*;

  // Labels arrive as 16-bit fields, so at most 16 bits are ever compared.
  localparam int LabW   = (LABEL_BITS < IN_LABEL_W) ? LABEL_BITS : IN_LABEL_W;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CtrlW  = $bits(lbm_ctrl_t);
  localparam int RgbW   = $bits(lbm_rgb_t);
  localparam int CmdW   = CtrlW + LabW + RgbW + AW;

  logic               q_push, q_full, q_pop, q_valid;
  logic [CmdW-1:0]    q_wdata, q_rdata;
  lbm_ctrl_t          f_ctrl, b_ctrl;
  logic [LabW-1:0]    f_label, b_label;
  lbm_rgb_t           f_rgb, b_rgb;
  logic [AW-1:0]      f_addr, b_addr;

  assign cfg_ready_o = 1'b1;

  lbm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .LAB_W     (LabW),
    .AW        (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .cmd_ctrl_o  (f_ctrl),
    .cmd_label_o (f_label),
    .cmd_rgb_o   (f_rgb),
    .cmd_addr_o  (f_addr)
  );

  assign q_wdata = {f_ctrl, f_label, f_rgb, f_addr};

  lbm_cmd_queue #(
    .DATA_W (CmdW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign b_ctrl  = lbm_ctrl_t'(q_rdata[CmdW-1 -: CtrlW]);
  assign b_label = q_rdata[AW+RgbW +: LabW];
  assign b_rgb   = lbm_rgb_t'(q_rdata[AW +: RgbW]);
  assign b_addr  = q_rdata[AW-1:0];

  lbm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .LAB_W     (LabW),
    .AW        (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .cmd_ctrl_i  (b_ctrl),
    .cmd_label_i (b_label),
    .cmd_rgb_i   (b_rgb),
    .cmd_addr_i  (b_addr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Every accepted pixel advances the window, so it must reach the queue.
  a_pixel_enqueued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.op == OP_PIXEL) |-> q_push)
    else $error("accepted pixel word was not queued");

  // A held result freezes the back end, so nothing may leave the queue.
  a_back_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop)
    else $error("queue popped while the output word was held");

  a_boundary_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.on_boundary) |->
      (out_o.out_red == WHITE && out_o.out_green == WHITE && out_o.out_blue == WHITE))
    else $error("boundary word is not white");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for label_boundary_marker: random and directed frames,
// a bit-exact overlay predictor and an in-order result check. Uses lbm_pkg.

module tb_top;
  import lbm_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int LBL_DEPTH     = 2 * MAX_W + 2;
  localparam int RGB_DEPTH     = MAX_W + 1;
  localparam int IDLE_PCT      = 11;
  localparam int QUIET_FROM    = 1500;
  localparam int QUIET_TO      = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_WORDS  = 500;
  localparam int REPORT_LIMIT  = 40;
  localparam longint TIMEOUT_NS = 5_000_000;

  // Register indexes past the end of the register list; the block ignores them.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

  typedef enum {FR_FULL, FR_CUT, FR_SHORT_TAIL, FR_LONG_TAIL} frame_kind_e;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    lbm_in_t               word;
  } plan_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  lbm_in_t               in_i        = '0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  cfg_ready_o;
  lbm_out_t              out_o;

  label_boundary_marker #(
    .MAX_WIDTH (MAX_W),
    .LABEL_BITS(16)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  plan_t       plan_q[$];
  lbm_out_t    overlay_q[$];
  int unsigned mismatches = 0;
  int unsigned cyc        = 0;
  int unsigned settle     = 0;
  int unsigned gen_words  = 0;
  wire         quiet_span = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  // Predictor state: the label and colour stores, the frame counters and the frame size.
  logic [15:0]             lbl_mem [LBL_DEPTH];
  lbm_rgb_t                rgb_mem [RGB_DEPTH];
  int unsigned             in_cnt  = 0;
  int unsigned             out_cnt = 0;
  logic [WIDTH_REG_W-1:0]  cfg_w   = RESET_FRAME_WIDTH;
  logic [HEIGHT_REG_W-1:0] cfg_h   = RESET_FRAME_HEIGHT;

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_W) return MAX_W;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_h == 0) return 1;
    if (cfg_h > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_h;
  endfunction

  // The newest pixel is not in the store yet when it releases a result.
  function automatic logic [15:0] lbl_at(int unsigned q, bit live, int unsigned live_pos,
                                         logic [15:0] live_lab);
    if (live && q == live_pos) return live_lab;
    return lbl_mem[q % LBL_DEPTH];
  endfunction

  function automatic lbm_out_t overlay_of(int unsigned p, bit live, int unsigned live_pos,
                                          logic [15:0] live_lab);
    int unsigned w, h, x, y, v0, v1, u0, u1;
    logic [15:0] centre;
    bit          differs;
    lbm_rgb_t    rgb;
    lbm_out_t    r;
    w  = eff_w();
    h  = eff_h();
    x  = p % w;
    y  = p / w;
    v0 = (y > 0) ? y - 1 : 0;
    v1 = (y + 1 < h) ? y + 1 : h - 1;
    u0 = (x > 0) ? x - 1 : 0;
    u1 = (x + 1 < w) ? x + 1 : w - 1;
    centre  = lbl_at(p, live, live_pos, live_lab);
    differs = 1'b0;
    for (int unsigned v = v0; v <= v1; v++) begin
      for (int unsigned u = u0; u <= u1; u++) begin
        if (lbl_at(v * w + u, live, live_pos, live_lab) != centre) differs = 1'b1;
      end
    end
    rgb            = rgb_mem[p % RGB_DEPTH];
    r.out_red      = differs ? WHITE : rgb.red;
    r.out_green    = differs ? WHITE : rgb.green;
    r.out_blue     = differs ? WHITE : rgb.blue;
    r.on_boundary  = differs;
    r.end_of_frame = (p + 1 == w * h);
    return r;
  endfunction

  function automatic void mark_word(lbm_in_t wd);
    int unsigned w, h, total, k;
    w     = eff_w();
    h     = eff_h();
    total = w * h;
    if (wd.op == OP_FLUSH) begin
      // A flush only releases once the whole frame is in.
      if (in_cnt == total && out_cnt < total) begin
        overlay_q.push_back(overlay_of(out_cnt, 1'b0, 0, '0));
        out_cnt++;
        if (out_cnt == total) begin
          in_cnt  = 0;
          out_cnt = 0;
        end
      end
    end else begin
      if (in_cnt >= total) begin
        in_cnt  = 0;
        out_cnt = 0;
      end
      k = in_cnt;
      if (k >= w + 1) begin
        overlay_q.push_back(overlay_of(k - w - 1, 1'b1, k, wd.seg_label));
        out_cnt = k - w;
      end
      lbl_mem[k % LBL_DEPTH] = wd.seg_label;
      rgb_mem[k % RGB_DEPTH] = {wd.in_red, wd.in_green, wd.in_blue};
      in_cnt = k + 1;
    end
  endfunction

  function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    if (idx == REG_FRAME_WIDTH) begin
      cfg_w   = data[WIDTH_REG_W-1:0];
      in_cnt  = 0;
      out_cnt = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      cfg_h   = data[HEIGHT_REG_W-1:0];
      in_cnt  = 0;
      out_cnt = 0;
    end
  endfunction

  function automatic int field_bad(string name, logic [7:0] want, logic [7:0] got, bit loud);
    if (want !== got) begin
      if (loud) $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_t e;
    e.is_cfg = 1'b1;
    e.idx    = idx;
    e.data   = data;
    e.word   = '0;
    plan_q.push_back(e);
  endtask

  task automatic add_word(logic op, logic [15:0] lab, logic [23:0] rgb);
    plan_t e;
    e.is_cfg         = 1'b0;
    e.idx            = '0;
    e.data           = '0;
    e.word.op        = op;
    e.word.seg_label = lab;
    e.word.in_red    = rgb[23:16];
    e.word.in_green  = rgb[15:8];
    e.word.in_blue   = rgb[7:0];
    plan_q.push_back(e);
    gen_words++;
  endtask

  // Writes both size registers, using the out-of-range encodings at random.
  task automatic add_size(int unsigned w, int unsigned h);
    logic [CFG_DATA_W-1:0] wd, hd;
    wd = CFG_DATA_W'(w);
    wd[CFG_DATA_W-1:WIDTH_REG_W] = $urandom;
    if (w == 1 && $urandom_range(0, 1) == 1) wd[WIDTH_REG_W-1:0] = '0;
    if (w == MAX_W && $urandom_range(0, 1) == 1)
      wd[WIDTH_REG_W-1:0] = $urandom_range(MAX_W + 1, 2047);
    hd = CFG_DATA_W'(h);
    if (h == 1 && $urandom_range(0, 1) == 1) hd = '0;
    if (h == MAX_HEIGHT && $urandom_range(0, 1) == 1) hd = $urandom_range(MAX_HEIGHT + 1, 8191);
    if ($urandom_range(0, 3) == 0)
      add_cfg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
    if ($urandom_range(0, 1) == 1) begin
      add_cfg(REG_FRAME_WIDTH, wd);
      add_cfg(REG_FRAME_HEIGHT, hd);
    end else begin
      add_cfg(REG_FRAME_HEIGHT, hd);
      add_cfg(REG_FRAME_WIDTH, wd);
    end
  endtask

  // One frame of blocky label regions with some label noise and stray flushes.
  task automatic add_frame(int unsigned w, int unsigned h, frame_kind_e kind);
    int unsigned total, pend, n_pix, tail, bx, by;
    logic [15:0] pal [3];
    logic [15:0] lab;
    bit          flat;
    total = w * h;
    pend  = (total < w + 1) ? total : w + 1;
    n_pix = total;
    tail  = pend;
    case (kind)
      FR_CUT: begin
        n_pix = $urandom_range(1, total);
        tail  = 0;
      end
      FR_SHORT_TAIL: tail = $urandom_range(0, pend - 1);
      FR_LONG_TAIL:  tail = pend + $urandom_range(1, 2);
      default: ;
    endcase
    foreach (pal[i]) pal[i] = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      pal[0] = 16'h0000;
      pal[1] = 16'hFFFF;
    end
    flat = ($urandom_range(0, 5) == 0);
    bx   = $urandom_range(1, w);
    by   = $urandom_range(1, h);
    for (int unsigned p = 0; p < n_pix; p++) begin
      if ($urandom_range(0, 99) < 4) add_word(OP_FLUSH, $urandom, $urandom);
      lab = flat ? pal[0] : pal[((p % w) / bx + (p / w) / by) % 3];
      if (!flat && $urandom_range(0, 99) < 8) lab = pal[$urandom_range(0, 2)];
      add_word(OP_PIXEL, lab, $urandom);
    end
    repeat (tail) add_word(OP_FLUSH, $urandom, $urandom);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // Input side: words leave the plan queue one per handshake; register writes wait
  // until every expected result is out and the block has had time to settle.
  always @(posedge clk_i) begin : drive
    logic [$bits(lbm_in_t)-1:0] junk;
    logic  gap;
    logic  word_gone;
    logic  next_valid;
    plan_t head;
    junk = {$urandom, $urandom};
    gap  = !quiet_span && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (in_valid_i && !in_stall_o) mark_word(in_i);
      if (cfg_valid_i && cfg_ready_o) begin
        apply_size_write(cfg_index_i, cfg_data_i);
        cfg_valid_i <= 1'b0;
      end
      word_gone = !in_valid_i || !in_stall_o;
      if (word_gone) begin
        next_valid = 1'b0;
        if (plan_q.size() != 0 && !plan_q[0].is_cfg && !cfg_valid_i && !gap) begin
          head       = plan_q.pop_front();
          in_i      <= head.word;
          next_valid = 1'b1;
        end else begin
          in_i <= junk;
        end
        in_valid_i <= next_valid;
      end
      if (word_gone && !cfg_valid_i && plan_q.size() != 0 && plan_q[0].is_cfg) begin
        if (settle >= SETTLE_CYCLES) begin
          head         = plan_q.pop_front();
          cfg_index_i <= head.idx;
          cfg_data_i  <= head.data;
          cfg_valid_i <= 1'b1;
          settle      <= 0;
        end else if (overlay_q.size() == 0 && !in_valid_i) begin
          settle <= settle + 1;
        end else begin
          settle <= 0;
        end
      end
    end
  end

  // Output side: random stall, and an in-order check of every accepted word.
  always @(posedge clk_i) begin : monitor
    lbm_out_t want;
    int       bad;
    bit       loud;
    if (rst_ni) begin
      loud = (mismatches < REPORT_LIMIT);
      if (out_valid_o && !out_stall_i) begin
        if (overlay_q.size() == 0) begin
          if (loud) $display("%0t ns: expected no result, got %p", $time, out_o);
          mismatches <= mismatches + 1;
        end else begin
          want = overlay_q.pop_front();
          bad  = field_bad("out_red", want.out_red, out_o.out_red, loud)
               + field_bad("out_green", want.out_green, out_o.out_green, loud)
               + field_bad("out_blue", want.out_blue, out_o.out_blue, loud)
               + field_bad("on_boundary", want.on_boundary, out_o.on_boundary, loud)
               + field_bad("end_of_frame", want.end_of_frame, out_o.end_of_frame, loud);
          if (bad != 0) mismatches <= mismatches + 1;
        end
      end
      out_stall_i <= !quiet_span && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    int unsigned w, h, pick, phase, keep;
    frame_kind_e kind;

    // The first words run at the reset frame size, far enough to release a few results.
    for (int i = 0; i < 650; i++)
      add_word(OP_PIXEL, ($urandom_range(0, 3) == 0) ? 16'h0F0F : 16'hF0F0, $urandom);

    // Three by two frame with extreme labels and colours, a flush inside the
    // frame and one flush more than there are pending pixels.
    add_cfg(REG_FRAME_WIDTH, 13'h1803);
    add_cfg(REG_FRAME_HEIGHT, 13'd2);
    add_word(OP_PIXEL, 16'h0000, 24'h000000);
    add_word(OP_PIXEL, 16'h0000, 24'hFFFFFF);
    add_word(OP_FLUSH, 16'hFFFF, 24'hFFFFFF);
    add_word(OP_PIXEL, 16'hFFFF, 24'hA5C30F);
    add_word(OP_PIXEL, 16'h0000, 24'h5A3CF0);
    add_word(OP_PIXEL, 16'h0000, 24'h123456);
    add_word(OP_PIXEL, 16'hFFFF, 24'hFFFFFF);
    repeat (5) add_word(OP_FLUSH, 16'h0000, 24'h000000);

    // Writes to unused indexes mid-frame must not restart the frame. The frame is
    // then only partly flushed, and the next pixel starts a new one.
    repeat (3) add_word(OP_PIXEL, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, $urandom);
    add_cfg(IDX_SPARE_A, 13'h1FFF);
    add_cfg(IDX_SPARE_B, 13'h0000);
    repeat (3) add_word(OP_PIXEL, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, $urandom);
    add_word(OP_FLUSH, $urandom, $urandom);
    repeat (2) add_word(OP_PIXEL, $urandom, $urandom);

    // Zero sizes behave as one; sizes past the maximum saturate.
    add_cfg(REG_FRAME_WIDTH, 13'h0000);
    add_cfg(REG_FRAME_HEIGHT, 13'h0000);
    add_word(OP_PIXEL, 16'hFFFF, 24'hFFFFFF);
    repeat (2) add_word(OP_FLUSH, 16'h0000, 24'h000000);
    add_cfg(REG_FRAME_WIDTH, 13'h07FF);
    add_cfg(REG_FRAME_HEIGHT, 13'h1FFF);
    repeat (3) add_word(OP_PIXEL, $urandom, $urandom);

    gen_words = 0;
    phase     = 0;
    while (gen_words < RANDOM_WORDS) begin
      if (phase == 2 || phase == 5) begin
        // One widest frame and one tallest frame, left out of the word count.
        keep = gen_words;
        w    = (phase == 2) ? MAX_W : 1;
        h    = (phase == 2) ? 2 : MAX_HEIGHT;
        add_size(w, h);
        add_frame(w, h, FR_FULL);
        gen_words = keep;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end else if (pick < 9) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 3);
        h = $urandom_range(7, 24);
      end
      add_size(w, h);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0:       kind = FR_CUT;
          1:       kind = FR_SHORT_TAIL;
          2:       kind = FR_LONG_TAIL;
          default: kind = FR_FULL;
        endcase
        add_frame(w, h, kind);
      end
      phase++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (plan_q.size() != 0 || in_valid_i || cfg_valid_i || overlay_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && overlay_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== label_boundary_marker.f =====
design/lbm_pkg.sv
design/lbm_front.sv
design/lbm_cmd_queue.sv
design/lbm_back.sv
design/label_boundary_marker.sv
verif/tb_top.sv
